FILE: rtl/sts_pkg.sv
package sts_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int LEV_BITS   = 4;
    // prep, normalize prep, one stage per quotient bit, saturate
    localparam int LANE_LAT   = FRAC_BITS + 4;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [2:0][COORD_BITS-1:0] vec_t;

    typedef struct packed {
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_a_z;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_b_z;
        coord_t vert_c_x;
        coord_t vert_c_y;
        coord_t vert_c_z;
        logic [LEV_BITS-1:0] levels_left;
    } tri_beat_t;

    typedef struct packed {
        coord_t out_a_x;
        coord_t out_a_y;
        coord_t out_a_z;
        coord_t out_b_x;
        coord_t out_b_y;
        coord_t out_b_z;
        coord_t out_c_x;
        coord_t out_c_y;
        coord_t out_c_z;
        logic [LEV_BITS-1:0] levels_after;
        logic is_leaf;
        logic last_of_run;
    } res_beat_t;

    typedef struct packed {
        vec_t a;
        vec_t b;
        vec_t c;
        vec_t v1;
        vec_t v2;
        vec_t v3;
        logic [LEV_BITS-1:0] lev;
    } item_t;

endpackage

FILE: rtl/sts_lane.sv
module sts_lane (
    input  logic         clk,
    input  logic         adv,
    input  sts_pkg::vec_t p,
    input  sts_pkg::vec_t q,
    output sts_pkg::vec_t v
);

    localparam int CB  = sts_pkg::COORD_BITS;
    localparam int F   = sts_pkg::FRAC_BITS;
    localparam int SW  = CB + 1;
    localparam int SQW = 2 * CB + 1;
    localparam int LW  = 2 * CB + 2;
    localparam int W   = 2 * CB + 2 * F + 5;
    localparam int QW  = F + 1;
    localparam int NS  = F + 1;
    localparam int EW  = QW + CB;
    localparam logic [EW-1:0] MAXC = (EW'(1) << (CB - 1)) - EW'(1);

    logic [SW-1:0]    s_c [0:2];
    logic [SW-1:0]    m_c [0:2];
    logic [2*SW-1:0]  prod_c [0:2];
    logic             neg_a_reg [0:2];
    logic [SQW-1:0]   sq_a_reg [0:2];

    logic [W-1:0]     r_st  [0:NS][0:2];
    logic [W-1:0]     p_st  [0:NS][0:2];
    logic [W-1:0]     lq_st [0:NS][0:2];
    logic [QW-1:0]    q_st  [0:NS][0:2];
    logic             neg_st [0:NS][0:2];
    logic [LW-1:0]    l_st  [0:NS];

    logic [CB-1:0]    res_reg [0:2];

    // edge sum, magnitude and square
    for (genvar i = 0; i < 3; i++) begin : g_prep
        assign s_c[i]    = {p[i][CB-1], p[i]} + {q[i][CB-1], q[i]};
        assign m_c[i]    = s_c[i][SW-1] ? (~s_c[i] + SW'(1)) : s_c[i];
        assign prod_c[i] = m_c[i] * m_c[i];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                neg_a_reg[i] <= s_c[i][SW-1];
                sq_a_reg[i]  <= prod_c[i][SQW-1:0];
                r_st[0][i]   <= W'(sq_a_reg[i]) << (2 * F);
                p_st[0][i]   <= '0;
                lq_st[0][i]  <= '0;
                q_st[0][i]   <= '0;
                neg_st[0][i] <= neg_a_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_st[0] <= LW'(sq_a_reg[0]) + LW'(sq_a_reg[1]) + LW'(sq_a_reg[2]);
        end
    end

    // one quotient bit per stage, msb first; q*q*L and q*L kept incrementally
    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam int B = F - k;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                l_st[k+1] <= l_st[k];
            end
        end
        for (genvar i = 0; i < 3; i++) begin : g_comp
            logic [W-1:0] cand;
            logic         take;
            assign cand = p_st[k][i] + (lq_st[k][i] << (B + 1)) + (W'(l_st[k]) << (2 * B));
            assign take = cand <= r_st[k][i];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_st[k+1][i]   <= r_st[k][i];
                    neg_st[k+1][i] <= neg_st[k][i];
                    p_st[k+1][i]   <= take ? cand : p_st[k][i];
                    lq_st[k+1][i]  <= take ? (lq_st[k][i] + (W'(l_st[k]) << B)) : lq_st[k][i];
                    q_st[k+1][i]   <= take ? (q_st[k][i] | (QW'(1) << B)) : q_st[k][i];
                end
            end
        end
    end

    // sign, saturation, zero-length sum
    for (genvar i = 0; i < 3; i++) begin : g_out
        logic [EW-1:0] q_big;
        logic [EW-1:0] lim;
        logic [EW-1:0] mg;
        logic [CB-1:0] res_next;
        always_comb
        begin
            q_big = EW'(q_st[NS][i]);
            lim   = neg_st[NS][i] ? (MAXC + EW'(1)) : MAXC;
            mg    = (q_big > lim) ? lim : q_big;
            if (l_st[NS] == '0)
            begin
                res_next = '0;
            end
            else if (neg_st[NS][i])
            begin
                res_next = CB'(~mg + EW'(1));
            end
            else
            begin
                res_next = CB'(mg);
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                res_reg[i] <= res_next;
            end
        end
        assign v[i] = res_reg[i];
    end

endmodule

FILE: rtl/sts_emit.sv
module sts_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    input  sts_pkg::item_t     item,
    output logic               ready,
    output logic               res_valid,
    input  logic               res_stall,
    output sts_pkg::res_beat_t res_beat
);

    sts_pkg::item_t item_reg;
    logic           full_reg;
    logic           full_next;
    logic [1:0]     beat_reg;
    logic [1:0]     beat_next;
    logic           leaf;
    logic           last;
    sts_pkg::vec_t  ra;
    sts_pkg::vec_t  rb;
    sts_pkg::vec_t  rc;

    assign leaf  = item_reg.lev == '0;
    assign last  = leaf || (beat_reg == 2'd3);
    assign ready = !full_reg || (!res_stall && last);

    always_comb
    begin
        full_next = full_reg;
        beat_next = beat_reg;
        if (ready)
        begin
            full_next = load_valid;
            beat_next = '0;
        end
        else if (!res_stall)
        begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            beat_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load_valid)
        begin
            item_reg <= item;
        end
    end

    // child order of one split; a leaf passes its own triangle through
    always_comb
    begin
        if (leaf)
        begin
            ra = item_reg.a;
            rb = item_reg.b;
            rc = item_reg.c;
        end
        else
        begin
            unique case (beat_reg)
                2'd0:
                begin
                    ra = item_reg.a;  rb = item_reg.v1; rc = item_reg.v2;
                end
                2'd1:
                begin
                    ra = item_reg.v1; rb = item_reg.b;  rc = item_reg.v3;
                end
                2'd2:
                begin
                    ra = item_reg.v1; rb = item_reg.v3; rc = item_reg.v2;
                end
                default:
                begin
                    ra = item_reg.v2; rb = item_reg.v3; rc = item_reg.c;
                end
            endcase
        end
    end

    assign res_valid             = full_reg;
    assign res_beat.out_a_x      = ra[0];
    assign res_beat.out_a_y      = ra[1];
    assign res_beat.out_a_z      = ra[2];
    assign res_beat.out_b_x      = rb[0];
    assign res_beat.out_b_y      = rb[1];
    assign res_beat.out_b_z      = rb[2];
    assign res_beat.out_c_x      = rc[0];
    assign res_beat.out_c_y      = rc[1];
    assign res_beat.out_c_z      = rc[2];
    assign res_beat.levels_after = leaf ? '0 : (item_reg.lev - sts_pkg::LEV_BITS'(1));
    assign res_beat.is_leaf      = leaf;
    assign res_beat.last_of_run  = last;

endmodule

FILE: rtl/sphere_triangle_subdivider.sv
// channel | dir | handshake           | payload
// tri     | in  | tri_valid/tri_stall | tri_beat  (three vertices, levels left)
// res     | out | res_valid/res_stall | res_beat  (one triangle per beat)
//
// a triangle with levels left gives four beats, one per cycle while res is not stalled,
// and a leaf gives one; the emitter takes the next item as the last beat leaves
// an accepted beat passes the three normalize lanes (one stage per quotient bit)
// and then the emitter's item register before its first result beat
// reset clears the valid bits of the lane pipeline and the output register
// a stall on res freezes the whole pipeline once its last stage and the emitter both hold an item

module sphere_triangle_subdivider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tri_valid,
    output logic               tri_stall,
    input  sts_pkg::tri_beat_t tri_beat,
    output logic               res_valid,
    input  logic               res_stall,
    output sts_pkg::res_beat_t res_beat
);

    localparam int LAT = sts_pkg::LANE_LAT;

    sts_pkg::tri_beat_t dly_reg [0:LAT-1];
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;
    logic               adv;
    logic               ready;
    sts_pkg::vec_t      in_a;
    sts_pkg::vec_t      in_b;
    sts_pkg::vec_t      in_c;
    sts_pkg::vec_t      v1;
    sts_pkg::vec_t      v2;
    sts_pkg::vec_t      v3;
    sts_pkg::item_t     item;

    assign in_a = {tri_beat.vert_a_z, tri_beat.vert_a_y, tri_beat.vert_a_x};
    assign in_b = {tri_beat.vert_b_z, tri_beat.vert_b_y, tri_beat.vert_b_x};
    assign in_c = {tri_beat.vert_c_z, tri_beat.vert_c_y, tri_beat.vert_c_x};

    assign adv       = !vld_reg[LAT-1] || ready;
    assign tri_stall = !adv;
    assign vld_next  = adv ? {vld_reg[LAT-2:0], tri_valid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // original triangle travels alongside the lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_reg[0] <= tri_beat;
            for (int i = 1; i < LAT; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    sts_lane u_lane_ab (.clk(clk), .adv(adv), .p(in_a), .q(in_b), .v(v1));
    sts_lane u_lane_ac (.clk(clk), .adv(adv), .p(in_a), .q(in_c), .v(v2));
    sts_lane u_lane_bc (.clk(clk), .adv(adv), .p(in_b), .q(in_c), .v(v3));

    assign item.a   = {dly_reg[LAT-1].vert_a_z, dly_reg[LAT-1].vert_a_y,
                       dly_reg[LAT-1].vert_a_x};
    assign item.b   = {dly_reg[LAT-1].vert_b_z, dly_reg[LAT-1].vert_b_y,
                       dly_reg[LAT-1].vert_b_x};
    assign item.c   = {dly_reg[LAT-1].vert_c_z, dly_reg[LAT-1].vert_c_y,
                       dly_reg[LAT-1].vert_c_x};
    assign item.v1  = v1;
    assign item.v2  = v2;
    assign item.v3  = v3;
    assign item.lev = dly_reg[LAT-1].levels_left;

    sts_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_valid(vld_reg[LAT-1]),
        .item      (item),
        .ready     (ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule
